// File: rtl/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

	// Operation codes carried on the opcode port.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	// Width of the entry_count port.
	localparam int unsigned CNT_W = 6;

	// Control part of a request as it moves from cell to cell.
	typedef struct packed {
		logic       vld;
		logic [1:0] op;
		logic       hit;
		logic       free_seen;
	} kvt_ctl_t;

endpackage

`default_nettype wire

// File: rtl/kvt_cell.sv
`default_nettype none

// One table entry plus the stage register that passes a request on to the next cell.
module kvt_cell #(
	parameter int CAPACITY   = 32,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 32,
	parameter int IDX        = 0
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire kvt_pkg::kvt_ctl_t       ctl_i,
	input  wire [KEY_BITS-1:0]           key_i,
	input  wire [VALUE_BITS-1:0]         val_i,
	input  wire [VALUE_BITS-1:0]         rd_i,
	input  wire [$clog2(CAPACITY)-1:0]   fidx_i,
	output kvt_pkg::kvt_ctl_t            ctl_o,
	output logic [KEY_BITS-1:0]          key_o,
	output logic [VALUE_BITS-1:0]        val_o,
	output logic [VALUE_BITS-1:0]        rd_o,
	output logic [$clog2(CAPACITY)-1:0]  fidx_o,
	input  wire                          wr_en,
	input  wire [$clog2(CAPACITY)-1:0]   wr_idx,
	input  wire [KEY_BITS-1:0]           wr_key,
	input  wire [VALUE_BITS-1:0]         wr_val
);

	localparam int IDX_W = $clog2(CAPACITY);

	logic                  ent_vld_q;
	logic [KEY_BITS-1:0]   ent_key_q;
	logic [VALUE_BITS-1:0] ent_val_q;
	kvt_pkg::kvt_ctl_t     ctl_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] rd_q;
	logic [IDX_W-1:0]      fidx_q;

	logic match;
	logic take_wr;
	logic first_free;

	assign match      = ctl_i.vld && ent_vld_q && (ent_key_q == key_i);
	assign take_wr    = wr_en && (wr_idx == IDX_W'(IDX));
	assign first_free = !ctl_i.free_seen && !ent_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= 1'b0;
		end else if (take_wr) begin
			ent_vld_q <= 1'b1;
		end else if (match && ctl_i.op == kvt_pkg::OP_DELETE) begin
			ent_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_wr) begin
			ent_key_q <= wr_key;
			ent_val_q <= wr_val;
		end else if (match && ctl_i.op == kvt_pkg::OP_INSERT) begin
			ent_val_q <= val_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.vld       <= ctl_i.vld;
			ctl_q.op        <= ctl_i.op;
			ctl_q.hit       <= ctl_i.hit || match;
			ctl_q.free_seen <= ctl_i.free_seen || !ent_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= key_i;
		val_q  <= val_i;
		rd_q   <= match ? ent_val_q : rd_i;
		fidx_q <= first_free ? IDX_W'(IDX) : fidx_i;
	end

	assign ctl_o  = ctl_q;
	assign key_o  = key_q;
	assign val_o  = val_q;
	assign rd_o   = rd_q;
	assign fidx_o = fidx_q;

endmodule

`default_nettype wire

// File: rtl/key_value_table.sv
`default_nettype none

// Key-value table with unique keys, built as a row of CAPACITY cells that each hold one
// entry. An item is taken at a rising edge where start is high and busy is low; it then
// walks the row one cell per clock, every cell comparing the key with its own entry. The
// result is registered onto the outputs as the item leaves the last cell. Busy is high
// while the item walks the row and drops in the cycle where done is high, so the next
// item can be taken at the edge that ends the result cycle; the table takes no new item
// before the last one's result is out. The length of the row of cells sets how long an
// item takes. Done is high for exactly one cycle, and the result appears on status,
// found, read_value and entry_count while it is high; the receiver cannot hold it off,
// so it must capture the result in that cycle. The result remains on the ports until
// the next result replaces it. Only the low KEY_BITS bits of key take part, and values
// are kept to VALUE_BITS bits. Reset clears every entry and the internal entry count;
// no clearing pass is needed. The entry_count port itself is not reset.
module key_value_table #(
	parameter int CAPACITY   = 32,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire  [1:0]         opcode,
	input  wire  [63:0]        key,
	input  wire  signed [31:0] value,
	output logic               done,
	output logic [1:0]         status,
	output logic               found,
	output logic signed [31:0] read_value,
	output logic [5:0]         entry_count
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int OCC_W = $clog2(CAPACITY + 1);

	// Signals between neighboring cells; index 0 is the row entrance and index
	// CAPACITY is the output of the last cell.
	kvt_pkg::kvt_ctl_t     ctl_c  [0:CAPACITY];
	logic [KEY_BITS-1:0]   key_c  [0:CAPACITY];
	logic [VALUE_BITS-1:0] val_c  [0:CAPACITY];
	logic [VALUE_BITS-1:0] rd_c   [0:CAPACITY];
	logic [IDX_W-1:0]      fidx_c [0:CAPACITY];
	logic [CAPACITY-1:0]   chain_vld;

	logic                   busy_q;
	logic [OCC_W-1:0]       occ_q;
	logic                   done_q;
	logic [1:0]             status_q;
	logic                   found_q;
	logic [31:0]            rd_q;
	logic [5:0]             cnt_q;

	logic                   accept;
	logic [VALUE_BITS+31:0] val_ext;
	kvt_pkg::kvt_ctl_t      fin;
	logic                   commit;
	logic                   remove;
	logic [OCC_W-1:0]       occ_next;
	logic [OCC_W+5:0]       cnt_ext;
	logic [VALUE_BITS+31:0] rd_ext;
	logic [1:0]             status_d;
	logic                   found_d;
	logic [31:0]            rd_d;

	assign accept = start && !busy_q;

	// The input value is sign-extended and then cut to the stored width.
	assign val_ext = {{VALUE_BITS{value[31]}}, value};

	assign ctl_c[0].vld       = accept;
	assign ctl_c[0].op        = opcode;
	assign ctl_c[0].hit       = 1'b0;
	assign ctl_c[0].free_seen = 1'b0;
	assign key_c[0]           = key[KEY_BITS-1:0];
	assign val_c[0]           = val_ext[VALUE_BITS-1:0];
	assign rd_c[0]            = '0;
	assign fidx_c[0]          = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		kvt_cell #(
			.CAPACITY   (CAPACITY),
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.IDX        (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ctl_c[i]),
			.key_i  (key_c[i]),
			.val_i  (val_c[i]),
			.rd_i   (rd_c[i]),
			.fidx_i (fidx_c[i]),
			.ctl_o  (ctl_c[i+1]),
			.key_o  (key_c[i+1]),
			.val_o  (val_c[i+1]),
			.rd_o   (rd_c[i+1]),
			.fidx_o (fidx_c[i+1]),
			.wr_en  (commit),
			.wr_idx (fidx_c[CAPACITY]),
			.wr_key (key_c[CAPACITY]),
			.wr_val (val_c[CAPACITY])
		);
		assign chain_vld[i] = ctl_c[i+1].vld;
	end

	// When the request leaves the last cell, every entry has been compared. Updates
	// and deletes of a present key were already done inside the matching cell; a new
	// key is written here into the lowest free cell that the row recorded.
	assign fin    = ctl_c[CAPACITY];
	assign commit = fin.vld && fin.op == kvt_pkg::OP_INSERT && !fin.hit && fin.free_seen;
	assign remove = fin.vld && fin.op == kvt_pkg::OP_DELETE && fin.hit;

	always_comb begin
		if (commit) begin
			occ_next = occ_q + OCC_W'(1);
		end else if (remove && occ_q != '0) begin
			occ_next = occ_q - OCC_W'(1);
		end else begin
			occ_next = occ_q;
		end
	end

	assign cnt_ext = {6'b0, occ_next};
	assign rd_ext  = {{32{rd_c[CAPACITY][VALUE_BITS-1]}}, rd_c[CAPACITY]};

	always_comb begin
		status_d = kvt_pkg::ST_OK;
		found_d  = 1'b0;
		rd_d     = '0;
		case (fin.op)
			kvt_pkg::OP_INSERT: begin
				found_d = fin.hit;
				if (!fin.hit && !fin.free_seen) begin
					status_d = kvt_pkg::ST_FULL;
				end
			end
			kvt_pkg::OP_DELETE: begin
				found_d = fin.hit;
				if (!fin.hit) begin
					status_d = kvt_pkg::ST_NOTFOUND;
				end
			end
			kvt_pkg::OP_LOOKUP: begin
				found_d = fin.hit;
				if (fin.hit) begin
					rd_d = rd_ext[31:0];
				end else begin
					status_d = kvt_pkg::ST_NOTFOUND;
				end
			end
			default: begin
				status_d = kvt_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			occ_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin.vld) begin
				busy_q <= 1'b0;
			end
			if (fin.vld) begin
				occ_q <= occ_next;
			end
			done_q <= fin.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.vld) begin
			status_q <= status_d;
			found_q  <= found_d;
			rd_q     <= rd_d;
			cnt_q    <= cnt_ext[5:0];
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign status      = status_q;
	assign found       = found_q;
	assign read_value  = rd_q;
	assign entry_count = cnt_q;

`ifndef NO_ASSERTIONS
	// Only one item is ever in the row of cells.
	a_one_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_vld))
		else $error("more than one item in the cell row");

	// The table is free again exactly when its result comes out.
	a_free_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// A result is only produced for an item that was accepted.
	a_done_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in progress");

	// The count never exceeds the number of cells.
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(CAPACITY))
		else $error("entry count beyond capacity");

	// A present key always gives an ok status.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == kvt_pkg::ST_OK)
		else $error("found key with error status");

	// A nonzero read value comes only from a key that was found.
	a_read_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && read_value != 0 |-> found)
		else $error("read value without a hit");
`endif

endmodule

`default_nettype wire
